/* sv/bspct_pkg.sv */
// Shared types and constants for the cubic B-spline tessellator.
// Used by bspct_div and bspline_curve_tessellator_core; no dependencies.
`default_nettype none
package bspct_pkg;
	localparam int MAX_SEGMENTS = 64;
	localparam int SEG_W        = 7;
	localparam int N2_W         = 13;
	localparam int N3_W         = 19;
	localparam int DEN_W        = 22;
	localparam int DIV_W        = DEN_W + 1;
	localparam int CRD_W        = 32;
	localparam int COEF_W       = 36;
	localparam int BN_W         = 43;
	localparam int CN_W         = 49;
	localparam int DN_W         = 55;
	localparam int ACC_W        = 58;
	localparam int NUM_W        = 60;
	localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(8);
	localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENTS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_N2,
		ST_N3,
		ST_COEF,
		ST_MUL,
		ST_INIT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic signed [31:0] res;
	} div_stat_t;
endpackage
`default_nettype wire

/* sv/bspline_curve_tessellator_core.sv */
// Uniform cubic B-spline tessellator: control points in, vertices out.
// A span point runs setup (N2, N3, then COEF, MUL, INIT per coordinate), then n
// vertices, each three divisions on the one shared bit-serial divider plus any
// output stall. Other points are only stored. One request is worked on at a time.
// Reset clears the window, the point count and sets segments_per_span to 8.
`default_nettype none
module bspline_curve_tessellator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bspct_pkg::SEG_W-1:0] segments_per_span,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [31:0]          ctrl_x,
	input  wire logic signed [31:0]          ctrl_y,
	input  wire logic signed [31:0]          ctrl_z,
	input  wire logic                        new_curve,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [31:0]               vert_x,
	output logic signed [31:0]               vert_y,
	output logic signed [31:0]               vert_z,
	output logic                             span_end
);
	import bspct_pkg::*;

	state_t state_q, state_d;
	logic [SEG_W-1:0] seg_q;
	logic [SEG_W-1:0] n_q;
	logic [N2_W-1:0]  n2_q;
	logic [N3_W-1:0]  n3_q;
	logic [DEN_W-1:0] den_q;
	logic [1:0]       held_q;
	logic [1:0]       crd_q;
	logic [SEG_W-1:0] vtx_q;
	logic signed [CRD_W-1:0] win_x_q [3];
	logic signed [CRD_W-1:0] win_y_q [3];
	logic signed [CRD_W-1:0] win_z_q [3];
	logic signed [CRD_W-1:0] p3_q [3];
	logic signed [COEF_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [BN_W-1:0] bn_q;
	logic signed [CN_W-1:0] cn_q;
	logic signed [DN_W-1:0] dn_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [ACC_W-1:0] d1_q [3];
	logic signed [ACC_W-1:0] d2_q [3];
	logic signed [ACC_W-1:0] d3_q [3];
	logic signed [31:0] vres_q [3];
	logic signed [COEF_W-1:0] p0, p1, p2, p3;
	logic [SEG_W-1:0] n_clamp;
	logic in_acc;
	logic last_vtx;
	div_req_t  dreq;
	div_stat_t dstat;

	bspct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.stat   (dstat)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = state_q == ST_EMIT;
	assign last_vtx  = vtx_q == n_q - SEG_W'(1);
	assign span_end  = last_vtx;
	assign vert_x    = vres_q[0];
	assign vert_y    = vres_q[1];
	assign vert_z    = vres_q[2];
	assign n_clamp   = (seg_q == '0) ? SEG_W'(1) : ((seg_q > SEG_MAX) ? SEG_MAX : seg_q);

	always_comb begin
		case (crd_q)
			2'd0: begin
				p0 = COEF_W'(win_x_q[0]); p1 = COEF_W'(win_x_q[1]);
				p2 = COEF_W'(win_x_q[2]); p3 = COEF_W'(p3_q[0]);
			end
			2'd1: begin
				p0 = COEF_W'(win_y_q[0]); p1 = COEF_W'(win_y_q[1]);
				p2 = COEF_W'(win_y_q[2]); p3 = COEF_W'(p3_q[1]);
			end
			default: begin
				p0 = COEF_W'(win_z_q[0]); p1 = COEF_W'(win_z_q[1]);
				p2 = COEF_W'(win_z_q[2]); p3 = COEF_W'(p3_q[2]);
			end
		endcase
	end

	assign dreq.start = state_q == ST_DIV_START;
	assign dreq.num   = (NUM_W'(acc_q[crd_q]) <<< 1) + NUM_W'(signed'({1'b0, den_q}));
	assign dreq.den   = den_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !new_curve && held_q == 2'd3) state_d = ST_N2;
			end
			ST_N2:   state_d = ST_N3;
			ST_N3:   state_d = ST_COEF;
			ST_COEF: state_d = ST_MUL;
			ST_MUL:  state_d = ST_INIT;
			ST_INIT: state_d = (crd_q == 2'd2) ? ST_DIV_START : ST_COEF;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (dstat.done) state_d = (crd_q == 2'd2) ? ST_EMIT : ST_DIV_START;
			end
			ST_EMIT: begin
				if (!out_stall) state_d = last_vtx ? ST_IDLE : ST_DIV_START;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= SEG_RESET;
			held_q  <= '0;
			crd_q   <= '0;
			vtx_q   <= '0;
			for (int k = 0; k < 3; k++) begin
				win_x_q[k] <= '0;
				win_y_q[k] <= '0;
				win_z_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) seg_q <= segments_per_span;
			case (state_q)
				ST_IDLE: begin
					crd_q <= '0;
					vtx_q <= '0;
					if (in_acc) begin
						if (new_curve) begin
							win_x_q[0] <= ctrl_x;
							win_y_q[0] <= ctrl_y;
							win_z_q[0] <= ctrl_z;
							held_q     <= 2'd1;
						end else if (held_q != 2'd3) begin
							win_x_q[held_q] <= ctrl_x;
							win_y_q[held_q] <= ctrl_y;
							win_z_q[held_q] <= ctrl_z;
							held_q          <= held_q + 2'd1;
						end
					end
				end
				ST_INIT: begin
					if (crd_q == 2'd2) begin
						crd_q <= '0;
						win_x_q[0] <= win_x_q[1]; win_x_q[1] <= win_x_q[2]; win_x_q[2] <= p3_q[0];
						win_y_q[0] <= win_y_q[1]; win_y_q[1] <= win_y_q[2]; win_y_q[2] <= p3_q[1];
						win_z_q[0] <= win_z_q[1]; win_z_q[1] <= win_z_q[2]; win_z_q[2] <= p3_q[2];
					end else begin
						crd_q <= crd_q + 2'd1;
					end
				end
				ST_DIV_WAIT: begin
					if (dstat.done) crd_q <= (crd_q == 2'd2) ? 2'd0 : crd_q + 2'd1;
				end
				ST_EMIT: begin
					if (!out_stall) vtx_q <= vtx_q + SEG_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p3_q[0] <= ctrl_x;
				p3_q[1] <= ctrl_y;
				p3_q[2] <= ctrl_z;
				n_q     <= n_clamp;
			end
			ST_N2: n2_q <= N2_W'(n_q) * N2_W'(n_q);
			ST_N3: begin
				n3_q  <= N3_W'(n2_q) * N3_W'(n_q);
			end
			ST_COEF: begin
				den_q <= DEN_W'(6 * n3_q);
				a_q   <= p3 - p0 + 3 * (p1 - p2);
				b_q   <= 3 * (p0 + p2) - 6 * p1;
				c_q   <= 3 * (p2 - p0);
				d_q   <= p0 + (p1 <<< 2) + p2;
			end
			ST_MUL: begin
				bn_q <= BN_W'(b_q) * BN_W'(signed'({1'b0, n_q}));
				cn_q <= CN_W'(c_q) * CN_W'(signed'({1'b0, n2_q}));
				dn_q <= DN_W'(d_q) * DN_W'(signed'({1'b0, n3_q}));
			end
			ST_INIT: begin
				acc_q[crd_q] <= ACC_W'(dn_q);
				d1_q[crd_q]  <= ACC_W'(a_q) + ACC_W'(bn_q) + ACC_W'(cn_q);
				d2_q[crd_q]  <= ACC_W'(6 * ACC_W'(a_q)) + (ACC_W'(bn_q) <<< 1);
				d3_q[crd_q]  <= ACC_W'(6 * ACC_W'(a_q));
			end
			ST_DIV_WAIT: begin
				if (dstat.done) vres_q[crd_q] <= dstat.res;
			end
			ST_EMIT: begin
				if (!out_stall) begin
					for (int k = 0; k < 3; k++) begin
						acc_q[k] <= acc_q[k] + d1_q[k];
						d1_q[k]  <= d1_q[k] + d2_q[k];
						d2_q[k]  <= d2_q[k] + d3_q[k];
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* sv/bspct_div.sv */
// Bit-serial rounding divider: floor((num) / (2*den)), saturated to 32 bits.
// Depends on bspct_pkg.
`default_nettype none
module bspct_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bspct_pkg::div_req_t  req,
	output bspct_pkg::div_stat_t      stat
);
	import bspct_pkg::*;

	logic [NUM_W-1:0] u_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] e_q;
	logic [5:0]       cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] e_in;
	logic [NUM_W-1:0] num_u;
	logic [DIV_W:0]   trial;
	logic             take;
	logic [31:0]      res;

	assign e_in  = {req.den, 1'b0};
	assign num_u = NUM_W'(req.num);
	assign trial = {rem_q, u_q[NUM_W-1]};
	assign take  = trial >= {1'b0, e_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[NUM_W-1];
			e_q   <= e_in;
			rem_q <= '0;
			u_q   <= req.num[NUM_W-1] ? (~num_u + NUM_W'(e_in)) : num_u;
		end else if (busy_q) begin
			rem_q <= take ? DIV_W'(trial - {1'b0, e_q}) : trial[DIV_W-1:0];
			u_q   <= {u_q[NUM_W-2:0], take};
		end
	end

	always_comb begin
		if (!neg_q) begin
			res = (u_q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : u_q[31:0];
		end else begin
			res = (u_q > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (~u_q[31:0] + 32'd1);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.res  = signed'(res);
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for bspline_curve_tessellator_core: streams control points,
// predicts each span's vertices by exact forward differencing and compares every vertex.
// Depends on bspct_pkg, bspct_div and the core RTL only.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bspct_pkg::*;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               last;
	} vertex_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               nc;
		logic               flat;
	} point_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic [SEG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic signed [31:0] ctrl_x = 0, ctrl_y = 0, ctrl_z = 0;
	logic new_curve = 0;
	logic out_stall = 0;
	wire cfg_ready, in_stall, out_valid, span_end;
	wire signed [31:0] vert_x, vert_y, vert_z;

	vertex_t vertex_q[$];
	logic signed [31:0] win[3][3];
	int held;
	logic [SEG_W-1:0] seg_cfg;
	int errors = 0;
	bit no_gaps = 0;
	bit long_hold = 0;

	bspline_curve_tessellator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .segments_per_span(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.ctrl_x(ctrl_x), .ctrl_y(ctrl_y), .ctrl_z(ctrl_z), .new_curve(new_curve),
		.out_valid(out_valid), .out_stall(out_stall),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .span_end(span_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#250ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic signed [31:0] round_sat(longint num, longint den);
		longint t, q;
		t = 2 * num + den;
		q = t / (2 * den);
		if ((t % (2 * den)) != 0 && t < 0) q--;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// Updates the point window and queues the vertices of the span it closes, if any.
	task automatic predict_span(logic signed [31:0] px, py, pz, logic nc, logic flat);
		logic signed [31:0] pt[3];
		logic signed [31:0] res[3][MAX_SEGMENTS];
		longint n, p0, p1, p2, p3, a, b, c, d, bn, acc, d1, d2, d3, den;
		vertex_t v;
		pt[0] = px; pt[1] = py; pt[2] = pz;
		if (nc) held = 0;
		if (held < 3) begin
			for (int k = 0; k < 3; k++) win[k][held] = pt[k];
			held++;
			return;
		end
		n = seg_cfg;
		if (n < 1) n = 1;
		if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
		for (int k = 0; k < 3; k++) begin
			p0 = win[k][0]; p1 = win[k][1]; p2 = win[k][2]; p3 = pt[k];
			a = -p0 + 3 * p1 - 3 * p2 + p3;
			b = 3 * p0 - 6 * p1 + 3 * p2;
			c = -3 * p0 + 3 * p2;
			d = p0 + 4 * p1 + p2;
			bn = b * n;
			den = 6 * n * n * n;
			acc = d * n * n * n;
			d1 = a + bn + c * n * n;
			d2 = 6 * a + 2 * bn;
			d3 = 6 * a;
			for (int i = 0; i < n; i++) begin
				res[k][i] = flat ? pt[k] : round_sat(acc, den);
				acc += d1;
				d1 += d2;
				d2 += d3;
			end
			win[k][0] = win[k][1]; win[k][1] = win[k][2]; win[k][2] = pt[k];
		end
		for (int i = 0; i < n; i++) begin
			v.x = res[0][i]; v.y = res[1][i]; v.z = res[2][i];
			v.last = (i == n - 1);
			vertex_q = {vertex_q, v};
		end
	endtask

	task automatic send_point(logic signed [31:0] px, py, pz, logic nc, logic flat);
		int gap;
		logic st;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		ctrl_x <= px; ctrl_y <= py; ctrl_z <= pz; new_curve <= nc;
		do begin
			@(negedge clk) st = in_stall;
			@(posedge clk);
		end while (st);
		predict_span(px, py, pz, nc, flat);
	endtask

	task automatic write_segments(logic [SEG_W-1:0] val);
		logic rdy;
		in_valid <= 0;
		@(posedge clk);
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= val;
		do begin
			@(negedge clk) rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 0;
		seg_cfg = val;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
			default: return $urandom();
		endcase
	endfunction

	// Receiver: random hold-off before each vertex, one long hold-off on request.
	initial begin
		int k;
		logic acc;
		forever begin
			if (long_hold) begin
				k = 400;
				long_hold = 0;
			end else begin
				k = no_gaps ? 0 : $urandom_range(0, 7);
			end
			if (k > 0) begin
				out_stall <= 1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 0;
			do begin
				@(negedge clk) acc = arst_n && out_valid;
				@(posedge clk);
			end while (!acc);
		end
	end

	always @(negedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				$display("%t unexpected vertex %h %h %h %b", $realtime,
					vert_x, vert_y, vert_z, span_end);
				errors++;
			end else begin
				e = vertex_q.pop_front();
				if (vert_x !== e.x || vert_y !== e.y || vert_z !== e.z ||
						span_end !== e.last) begin
					$display("%t vertex mismatch: expected %h %h %h %b, got %h %h %h %b",
						$realtime, e.x, e.y, e.z, e.last, vert_x, vert_y, vert_z, span_end);
					errors++;
				end
			end
		end
	end

	point_row_t dir_rows[] = '{
		'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0},
		'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0},
		'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0},
		'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 1},
		'{32'sh00000000, 32'sh00000000, 32'sh00000000, 1, 0},
		'{32'sh00000000, 32'sh00000000, 32'sh00000000, 0, 0},
		'{32'sh00000000, 32'sh00000000, 32'sh00000000, 0, 0},
		'{32'sh00000000, 32'sh00000000, 32'sh00000000, 0, 1},
		'{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 1, 0},
		'{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFF0000, 0, 0},
		'{32'sh7FFFFFFF, 32'sh80000000, 32'sh00008000, 0, 0},
		'{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 0, 0},
		'{32'sh12345678, 32'shEDCBA987, 32'sh00000001, 0, 0},
		'{32'sh00010000, 32'sh00020000, 32'sh00030000, 1, 0},
		'{32'sh00040000, 32'sh00050000, 32'sh00060000, 0, 0},
		'{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 0, 0},
		'{32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0, 0, 0}
	};

	logic [SEG_W-1:0] phase_seg[] = '{1, 64, 0, 2, 127, 3, 5, 4, 7, 2, 6, 8};
	int phase_len[] = '{40, 8, 30, 40, 7, 35, 30, 30, 25, 30, 20, 25};

	initial begin
		held = 0;
		seg_cfg = SEG_RESET;
		for (int k = 0; k < 3; k++)
			for (int j = 0; j < 3; j++) win[k][j] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
				dir_rows[r].nc, dir_rows[r].flat);

		foreach (phase_seg[p]) begin
			write_segments(phase_seg[p]);
			no_gaps = (p % 4 == 3);
			if (p == 3) long_hold = 1;
			for (int i = 0; i < phase_len[p]; i++)
				send_point(rand_coord(), rand_coord(), rand_coord(),
					(i == 0) || ($urandom_range(0, 11) == 0), 0);
		end
		no_gaps = 0;
		in_valid <= 0;

		while (vertex_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
